@@ rtl/vector_matrix_transform_macros.svh @@
// Assertion macros shared by the vector matrix transform RTL.
// Each macro expands to one labeled concurrent assertion with a synchronous reset guard.
`ifndef VECTOR_MATRIX_TRANSFORM_MACROS_SVH
`define VECTOR_MATRIX_TRANSFORM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vmt assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define VMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vmt assertion failed (next cycle)");

`endif

@@ rtl/vmt_pkg.sv @@
// Package for the vector matrix transform: widths, register map and shared types.
// Used by vmt_lane, vmt_merge and vector_matrix_transform; depends on nothing.
`default_nettype none

package vmt_pkg;

   localparam int DATA_W            = 32;
   localparam int PROD_W            = 2 * DATA_W;
   localparam int PAIR_W            = PROD_W + 1;
   localparam int SUM_W             = PROD_W + 2;
   localparam int VEC_LEN           = 4;
   localparam int NUM_LANES         = 4;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Configuration register map: two packed matrix elements per register.
   localparam int CSR_DATA_W  = 2 * DATA_W;
   localparam int CSR_INDEX_W = 4;
   localparam int NUM_CSR     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_RIGHT_01 = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_POS_23   = CSR_INDEX_W'(NUM_CSR - 1);

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] word_type;

   // Load enables for the three pipeline stages inside each lane.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
   } stage_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/vmt_lane.sv @@
// One output-component lane: four signed multiplies, a two-level adder tree, and the
// fixed-point shift with saturation. Depends on vmt_pkg.
`default_nettype none

module vmt_lane #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire vmt_pkg::stage_ctrl_type  ctrl,
   input  wire vmt_pkg::word_type        vec [vmt_pkg::VEC_LEN],
   input  wire vmt_pkg::word_type        coef [vmt_pkg::VEC_LEN],
   output vmt_pkg::word_type             result,
   output logic                          sat
);

   logic signed [vmt_pkg::PROD_W-1:0] prod_ff [vmt_pkg::VEC_LEN];
   logic signed [vmt_pkg::PROD_W-1:0] prod_in [vmt_pkg::VEC_LEN];
   logic signed [vmt_pkg::PAIR_W-1:0] pair_ff [2];
   logic signed [vmt_pkg::PAIR_W-1:0] pair_in [2];
   logic signed [vmt_pkg::SUM_W-1:0]  sum_ff;
   logic signed [vmt_pkg::SUM_W-1:0]  sum_in;
   logic signed [vmt_pkg::SUM_W-1:0]  shifted;
   logic [vmt_pkg::SUM_W-vmt_pkg::DATA_W:0] top_bits;
   logic fits;

   always_comb begin
      for (int i = 0; i < vmt_pkg::VEC_LEN; i++) begin
         prod_in[i] = vmt_pkg::PROD_W'(vec[i]) * vmt_pkg::PROD_W'(coef[i]);
      end
      pair_in[0] = vmt_pkg::PAIR_W'(prod_ff[0]) + vmt_pkg::PAIR_W'(prod_ff[1]);
      pair_in[1] = vmt_pkg::PAIR_W'(prod_ff[2]) + vmt_pkg::PAIR_W'(prod_ff[3]);
      sum_in     = vmt_pkg::SUM_W'(pair_ff[0]) + vmt_pkg::SUM_W'(pair_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         prod_ff <= prod_in;
      end
      if (ctrl.ld2) begin
         pair_ff <= pair_in;
      end
      if (ctrl.ld3) begin
         sum_ff <= sum_in;
      end
   end

   // The shifted sum fits in a word when every bit from the word's sign bit upward agrees.
   always_comb begin
      shifted  = sum_ff >>> FRAC_BITS;
      top_bits = shifted[vmt_pkg::SUM_W-1:vmt_pkg::DATA_W-1];
      fits     = (&top_bits) | ~(|top_bits);
      sat      = ~fits;
      if (fits) begin
         result = shifted[vmt_pkg::DATA_W-1:0];
      end else if (shifted[vmt_pkg::SUM_W-1]) begin
         result = vmt_pkg::SAT_MIN;
      end else begin
         result = vmt_pkg::SAT_MAX;
      end
   end

endmodule

`default_nettype wire

@@ rtl/vmt_merge.sv @@
// Output stage: gathers the four lane results, merges their saturation flags, and holds
// the result register of the response channel. Depends on vmt_pkg.
`default_nettype none

module vmt_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire vmt_pkg::word_type        lane_result [vmt_pkg::NUM_LANES],
   input  wire logic [vmt_pkg::NUM_LANES-1:0] lane_sat,
   output logic                          ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output vmt_pkg::word_type             rsp_out_x,
   output vmt_pkg::word_type             rsp_out_y,
   output vmt_pkg::word_type             rsp_out_z,
   output vmt_pkg::word_type             rsp_out_w,
   output logic                          rsp_clipped
);

   logic              valid_ff;
   logic              valid_in;
   vmt_pkg::word_type comp_ff [vmt_pkg::NUM_LANES];
   logic              clipped_ff;
   logic              load;

   // The register can take a new result when it is empty or its result leaves this cycle.
   assign ready    = ~valid_ff | ~rsp_stall;
   assign load     = ready & in_valid;
   assign valid_in = ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         comp_ff    <= lane_result;
         clipped_ff <= |lane_sat;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_out_x   = comp_ff[0];
   assign rsp_out_y   = comp_ff[1];
   assign rsp_out_z   = comp_ff[2];
   assign rsp_out_w   = comp_ff[3];
   assign rsp_clipped = clipped_ff;

endmodule

`default_nettype wire

@@ rtl/vector_matrix_transform.sv @@
// Vector times 4x4 matrix transform, signed fixed point with saturation.
//
// A request carries one vector (req_in_x .. req_in_w). It is multiplied as a row vector
// by the matrix held in eight 64-bit configuration registers (rows right, up, at, pos,
// two packed elements each, low element in bits 31..0). Writes go through csr_write,
// csr_index and csr_data; an index past the last register is ignored. Write the matrix
// only while no request is in flight.
// Each response carries the four transformed components and rsp_clipped, which is set
// when any component saturated.
// Four lanes, one per output component, run side by side; each is a multiply stage, two
// adder stages and a saturating shift, and the merge stage registers the response.
// An accepted request passes through the lane stage registers and the merge register to
// rsp_valid; one request is taken every cycle while req_stall is low.
// Every stage has its own valid bit, so empty stages fill while the response is stalled;
// req_stall rises only when all four stages hold requests and rsp_stall is high.
// Synchronous reset empties the pipeline and clears the matrix to zero.
`default_nettype none

`include "vector_matrix_transform_macros.svh"

module vector_matrix_transform #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [vmt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [vmt_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire vmt_pkg::word_type                 req_in_x,
   input  wire vmt_pkg::word_type                 req_in_y,
   input  wire vmt_pkg::word_type                 req_in_z,
   input  wire vmt_pkg::word_type                 req_in_w,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output vmt_pkg::word_type                      rsp_out_x,
   output vmt_pkg::word_type                      rsp_out_y,
   output vmt_pkg::word_type                      rsp_out_z,
   output vmt_pkg::word_type                      rsp_out_w,
   output logic                                   rsp_clipped
);

   vmt_pkg::word_type       mat_ff [vmt_pkg::VEC_LEN][vmt_pkg::NUM_LANES];
   logic [1:0]              csr_row;
   logic [1:0]              csr_col_lo;
   logic [1:0]              csr_col_hi;
   logic                    csr_hit;

   logic                    v1_ff, v2_ff, v3_ff;
   logic                    v1_in, v2_in, v3_in;
   logic                    can1, can2, can3;
   logic                    merge_ready;
   logic                    req_accept;
   vmt_pkg::stage_ctrl_type ctrl;

   vmt_pkg::word_type       vec [vmt_pkg::VEC_LEN];
   vmt_pkg::word_type       lane_result [vmt_pkg::NUM_LANES];
   logic [vmt_pkg::NUM_LANES-1:0] lane_sat;

   // Matrix registers: index bits 2..1 pick the row, bit 0 picks the element pair.
   assign csr_row    = csr_index[2:1];
   assign csr_col_lo = {csr_index[0], 1'b0};
   assign csr_col_hi = {csr_index[0], 1'b1};
   assign csr_hit    = (csr_index <= vmt_pkg::CSR_ROW_POS_23);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < vmt_pkg::VEC_LEN; r++) begin
            for (int c = 0; c < vmt_pkg::NUM_LANES; c++) begin
               mat_ff[r][c] <= '0;
            end
         end
      end else if (csr_write && csr_hit) begin
         mat_ff[csr_row][csr_col_lo] <= csr_data[vmt_pkg::DATA_W-1:0];
         mat_ff[csr_row][csr_col_hi] <= csr_data[vmt_pkg::CSR_DATA_W-1:vmt_pkg::DATA_W];
      end
   end

   // Each stage loads when it is empty or the stage after it can take its request.
   assign can3       = ~v3_ff | merge_ready;
   assign can2       = ~v2_ff | can3;
   assign can1       = ~v1_ff | can2;
   assign req_stall  = ~can1;
   assign req_accept = req_valid & can1;

   assign v1_in = can1 ? req_accept : v1_ff;
   assign v2_in = can2 ? v1_ff : v2_ff;
   assign v3_in = can3 ? v2_ff : v3_ff;

   assign ctrl.ld1 = req_accept;
   assign ctrl.ld2 = can2 & v1_ff;
   assign ctrl.ld3 = can3 & v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign vec[0] = req_in_x;
   assign vec[1] = req_in_y;
   assign vec[2] = req_in_z;
   assign vec[3] = req_in_w;

   for (genvar j = 0; j < vmt_pkg::NUM_LANES; j++) begin : g_lane
      vmt_pkg::word_type coef [vmt_pkg::VEC_LEN];

      always_comb begin
         for (int i = 0; i < vmt_pkg::VEC_LEN; i++) begin
            coef[i] = mat_ff[i][j];
         end
      end

      vmt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .vec    (vec),
         .coef   (coef),
         .result (lane_result[j]),
         .sat    (lane_sat[j])
      );
   end

   vmt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v3_ff),
      .lane_result (lane_result),
      .lane_sat    (lane_sat),
      .ready       (merge_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_out_w   (rsp_out_w),
      .rsp_clipped (rsp_clipped)
   );

   // A clipped response must show at least one component pinned at a saturation limit.
   `VMT_ASSERT_IMPLIES(a_clip_has_limit, clock, reset, rsp_valid && rsp_clipped, (rsp_out_x == vmt_pkg::SAT_MAX) || (rsp_out_x == vmt_pkg::SAT_MIN) || (rsp_out_y == vmt_pkg::SAT_MAX) || (rsp_out_y == vmt_pkg::SAT_MIN) || (rsp_out_z == vmt_pkg::SAT_MAX) || (rsp_out_z == vmt_pkg::SAT_MIN) || (rsp_out_w == vmt_pkg::SAT_MAX) || (rsp_out_w == vmt_pkg::SAT_MIN))
   // Requests are refused only when every stage is occupied and the output is held.
   `VMT_ASSERT_IMPLIES(a_stall_only_full, clock, reset, req_stall, v1_ff && v2_ff && v3_ff && rsp_valid && rsp_stall)
   // An accepted request always lands in the first stage.
   `VMT_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && !req_stall, v1_ff)
   // The pipeline comes out of reset empty.
   `VMT_ASSERT_IMPLIES(a_reset_empty, clock, reset, $past(reset), !rsp_valid && !v3_ff)

endmodule

`default_nettype wire
